[rtl/mx3i_pkg.sv]
package mx3i_pkg;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 32;
    localparam int NELEM  = 9;
    localparam int COF_W  = 2 * IN_W;
    localparam int PROD_W = IN_W + COF_W;
    localparam int DET_W  = PROD_W + 2;
    localparam int MAG_W  = DET_W - 1;
    localparam int DEN_W  = MAG_W + 1;
    localparam int QSHIFT = 28;
    localparam int NUM_W  = COF_W + QSHIFT + 2;
    localparam int QUO_W  = OUT_W + 1;
    localparam int DS_W   = DEN_W + QUO_W - 1;

    typedef logic signed [IN_W-1:0]  t_elem;
    typedef logic signed [OUT_W-1:0] t_res;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        logic [DS_W-1:0]         dsh;
        logic                    singular;
        t_lane [NELEM-1:0]       lane;
    } t_div;

endpackage

[rtl/mx3i_front.sv]
module mx3i_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  mx3i_pkg::t_elem      i_a [9],
    output logic                 o_valid,
    output mx3i_pkg::t_div       o_div
);
    import mx3i_pkg::*;

    function automatic logic signed [COF_W-1:0] cross2(
        input t_elem a, input t_elem b, input t_elem c, input t_elem d);
        logic signed [COF_W-1:0] pab;
        logic signed [COF_W-1:0] pcd;
        pab = COF_W'(a) * COF_W'(b);
        pcd = COF_W'(c) * COF_W'(d);
        return pab - pcd;
    endfunction

    logic [4:0]                r_vld;
    t_elem                     r_a   [NELEM];
    logic signed [COF_W-1:0]   r_adj2 [NELEM];
    t_elem                     r_row2 [3];
    logic signed [COF_W-1:0]   r_adj3 [NELEM];
    logic signed [PROD_W-1:0]  r_prod [3];
    logic signed [COF_W-1:0]   r_adj4 [NELEM];
    logic signed [DET_W-1:0]   r_det;
    logic signed [COF_W-1:0]   n_adj [NELEM];
    t_div                      n_div;
    t_div                      r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_comb begin
        n_adj[0] = cross2(r_a[4], r_a[8], r_a[5], r_a[7]);
        n_adj[1] = cross2(r_a[2], r_a[7], r_a[1], r_a[8]);
        n_adj[2] = cross2(r_a[1], r_a[5], r_a[2], r_a[4]);
        n_adj[3] = cross2(r_a[5], r_a[6], r_a[3], r_a[8]);
        n_adj[4] = cross2(r_a[0], r_a[8], r_a[2], r_a[6]);
        n_adj[5] = cross2(r_a[2], r_a[3], r_a[0], r_a[5]);
        n_adj[6] = cross2(r_a[3], r_a[7], r_a[4], r_a[6]);
        n_adj[7] = cross2(r_a[1], r_a[6], r_a[0], r_a[7]);
        n_adj[8] = cross2(r_a[0], r_a[4], r_a[1], r_a[3]);
    end

    // magnitudes, rounding bias and overflow precheck for the divider
    always_comb begin
        logic [MAG_W-1:0]  dmag;
        logic [DEN_W-1:0]  den;
        logic [COF_W-1:0]  cmag;
        logic [NUM_W-1:0]  num;
        dmag = r_det[DET_W-1] ? MAG_W'(-r_det) : MAG_W'(r_det);
        den  = {dmag, 1'b0};
        n_div.dsh      = DS_W'(den) << (QUO_W - 1);
        n_div.singular = (r_det == '0);
        for (int k = 0; k < NELEM; k++) begin
            cmag = r_adj4[k][COF_W-1] ? COF_W'(-r_adj4[k]) : COF_W'(r_adj4[k]);
            num  = NUM_W'({cmag, {(QSHIFT + 1){1'b0}}}) + NUM_W'(dmag);
            n_div.lane[k].rem = num;
            n_div.lane[k].quo = '0;
            n_div.lane[k].neg = r_adj4[k][COF_W-1] ^ r_det[DET_W-1];
            n_div.lane[k].ovf = ((DS_W + 1)'(num) >= ((DS_W + 1)'(den) << QUO_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= i_a;
            r_adj2 <= n_adj;
            r_row2 <= r_a[0:2];
            r_adj3 <= r_adj2;
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= PROD_W'(r_row2[j]) * PROD_W'(r_adj2[3 * j]);
            end
            r_adj4 <= r_adj3;
            r_det  <= DET_W'(r_prod[0]) + DET_W'(r_prod[1]) + DET_W'(r_prod[2]);
            r_div  <= n_div;
        end
    end

    assign o_valid = r_vld[4];
    assign o_div   = r_div;

endmodule

[rtl/mx3i_div_stage.sv]
module mx3i_div_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  mx3i_pkg::t_div   i_div,
    output logic             o_valid,
    output mx3i_pkg::t_div   o_div
);
    import mx3i_pkg::*;

    logic  r_valid;
    t_div  r_div;
    t_div  n_div;

    // one quotient bit per lane: subtract the shifted divisor where it fits
    always_comb begin
        logic           ge;
        logic [DS_W-1:0] wide;
        n_div     = i_div;
        n_div.dsh = i_div.dsh >> 1;
        for (int k = 0; k < NELEM; k++) begin
            wide = DS_W'(i_div.lane[k].rem);
            ge   = (wide >= i_div.dsh);
            n_div.lane[k].rem = ge ? NUM_W'(wide - i_div.dsh) : i_div.lane[k].rem;
            n_div.lane[k].quo = {i_div.lane[k].quo[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

[rtl/mx3i_back.sv]
module mx3i_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  mx3i_pkg::t_div   i_div,
    output logic             o_valid,
    output mx3i_pkg::t_res   o_inv [9],
    output logic             o_singular,
    output logic             o_saturated
);
    import mx3i_pkg::*;

    logic  r_valid;
    t_res  r_inv [NELEM];
    logic  r_singular;
    logic  r_saturated;
    t_res  n_inv [NELEM];
    logic  n_saturated;

    // clip to range, apply sign, zero everything for a singular matrix
    always_comb begin
        logic [QUO_W-1:0] limit;
        logic [QUO_W-1:0] mag;
        logic             over;
        n_saturated = 1'b0;
        for (int k = 0; k < NELEM; k++) begin
            limit = i_div.lane[k].neg ? (QUO_W'(1) << (OUT_W - 1))
                                      : ((QUO_W'(1) << (OUT_W - 1)) - QUO_W'(1));
            over  = i_div.lane[k].ovf || (i_div.lane[k].quo > limit);
            mag   = over ? limit : i_div.lane[k].quo;
            n_inv[k] = i_div.lane[k].neg ? OUT_W'(-mag) : OUT_W'(mag);
            if (i_div.singular) begin
                n_inv[k] = '0;
            end
            n_saturated = n_saturated | (over & ~i_div.singular);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inv       <= n_inv;
            r_singular  <= i_div.singular;
            r_saturated <= n_saturated;
        end
    end

    assign o_valid     = r_valid;
    assign o_inv       = r_inv;
    assign o_singular  = r_singular;
    assign o_saturated = r_saturated;

endmodule

[rtl/matrix3_inverse.sv]
// 3x3 matrix inverse by the adjugate. One matrix of signed Q4.12 elements is
// taken per transaction and the inverse comes out in signed Q16.16, rounded to
// nearest with ties away from zero and clipped to range (o_saturated flags any
// clip). A zero determinant gives o_singular with all elements zero. A new
// matrix is taken every cycle while o_stall is low; the path runs through five
// stages of cofactor, determinant and operand setup, a 33-stage divider that
// resolves one quotient bit per stage for all nine elements, and the output
// register. The whole pipeline holds while a result waits under i_stall.
module matrix3_inverse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  mx3i_pkg::t_elem      i_a00,
    input  mx3i_pkg::t_elem      i_a01,
    input  mx3i_pkg::t_elem      i_a02,
    input  mx3i_pkg::t_elem      i_a10,
    input  mx3i_pkg::t_elem      i_a11,
    input  mx3i_pkg::t_elem      i_a12,
    input  mx3i_pkg::t_elem      i_a20,
    input  mx3i_pkg::t_elem      i_a21,
    input  mx3i_pkg::t_elem      i_a22,
    output logic                 o_valid,
    input  logic                 i_stall,
    output mx3i_pkg::t_res       o_inv00,
    output mx3i_pkg::t_res       o_inv01,
    output mx3i_pkg::t_res       o_inv02,
    output mx3i_pkg::t_res       o_inv10,
    output mx3i_pkg::t_res       o_inv11,
    output mx3i_pkg::t_res       o_inv12,
    output mx3i_pkg::t_res       o_inv20,
    output mx3i_pkg::t_res       o_inv21,
    output mx3i_pkg::t_res       o_inv22,
    output logic                 o_singular,
    output logic                 o_saturated
);
    import mx3i_pkg::*;

    logic   w_en;
    t_elem  w_a   [NELEM];
    t_div   w_div [QUO_W + 1];
    logic   w_vld [QUO_W + 1];
    t_res   w_inv [NELEM];

    // advance everything unless a result is held at the output
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    assign w_a[0] = i_a00;
    assign w_a[1] = i_a01;
    assign w_a[2] = i_a02;
    assign w_a[3] = i_a10;
    assign w_a[4] = i_a11;
    assign w_a[5] = i_a12;
    assign w_a[6] = i_a20;
    assign w_a[7] = i_a21;
    assign w_a[8] = i_a22;

    mx3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_a     (w_a),
        .o_valid (w_vld[0]),
        .o_div   (w_div[0])
    );

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        mx3i_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_div   (w_div[g]),
            .o_valid (w_vld[g + 1]),
            .o_div   (w_div[g + 1])
        );
    end

    mx3i_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_vld[QUO_W]),
        .i_div       (w_div[QUO_W]),
        .o_valid     (o_valid),
        .o_inv       (w_inv),
        .o_singular  (o_singular),
        .o_saturated (o_saturated)
    );

    assign o_inv00 = w_inv[0];
    assign o_inv01 = w_inv[1];
    assign o_inv02 = w_inv[2];
    assign o_inv10 = w_inv[3];
    assign o_inv11 = w_inv[4];
    assign o_inv12 = w_inv[5];
    assign o_inv20 = w_inv[6];
    assign o_inv21 = w_inv[7];
    assign o_inv22 = w_inv[8];

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_inv00 == '0 && o_inv11 == '0 && o_inv22 == '0))
        else $error("singular result with nonzero elements");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_singular && o_saturated))
        else $error("singular and saturated both set");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[QUO_W] && o_stall) |=> w_vld[QUO_W])
        else $error("divider output lost during stall");

endmodule

[verif/matrix3_inverse_tb.sv]
`timescale 1ns / 1ps

module matrix3_inverse_tb;
    import mx3i_pkg::*;

    typedef struct {
        t_res inv [9];
        logic singular;
        logic saturated;
    } t_inverse;

    // Holds the expected inverses and checks each result against the oldest.
    class inverse_board;
        t_inverse pending[$];
        int errors;

        function automatic logic signed [127:0] div_round(
                logic [127:0] num, logic [127:0] den);
            logic [127:0] n;
            logic [127:0] d;
            n = (num << 1) + den;
            d = den << 1;
            return n / d;
        endfunction

        function void note_matrix(t_elem m [9]);
            t_inverse r;
            logic signed [63:0] a [9];
            logic signed [63:0] adj [9];
            logic signed [127:0] det;
            logic signed [127:0] num;
            logic [127:0] q;
            logic [127:0] lim;
            logic neg;
            for (int k = 0; k < 9; k++) a[k] = m[k];
            adj[0] = a[4] * a[8] - a[5] * a[7];
            adj[1] = a[2] * a[7] - a[1] * a[8];
            adj[2] = a[1] * a[5] - a[2] * a[4];
            adj[3] = a[5] * a[6] - a[3] * a[8];
            adj[4] = a[0] * a[8] - a[2] * a[6];
            adj[5] = a[2] * a[3] - a[0] * a[5];
            adj[6] = a[3] * a[7] - a[4] * a[6];
            adj[7] = a[1] * a[6] - a[0] * a[7];
            adj[8] = a[0] * a[4] - a[1] * a[3];
            det = 128'(a[0]) * adj[0] + 128'(a[1]) * adj[3] + 128'(a[2]) * adj[6];
            r.singular = (det == 0);
            r.saturated = 1'b0;
            for (int k = 0; k < 9; k++) begin
                if (r.singular) begin
                    r.inv[k] = '0;
                end else begin
                    num = 128'(adj[k]) <<< 28;
                    neg = (num < 0) != (det < 0);
                    q = div_round(num < 0 ? -num : num, det < 0 ? -det : det);
                    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
                    if (q > lim) begin
                        q = lim;
                        r.saturated = 1'b1;
                    end
                    r.inv[k] = neg ? t_res'(-q) : t_res'(q);
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_res got [9], logic sng, logic sat);
            t_inverse e;
            bit bad;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction");
                return;
            end
            e = pending.pop_front();
            bad = (sng !== e.singular) || (sat !== e.saturated);
            for (int k = 0; k < 9; k++) if (got[k] !== e.inv[k]) bad = 1;
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: singular %0b/%0b saturated %0b/%0b",
                             e.singular, sng, e.saturated, sat);
                    for (int k = 0; k < 9; k++)
                        $display("  inv[%0d] exp %0d got %0d", k, e.inv[k], got[k]);
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic o_stall, o_valid, o_singular, o_saturated;
    t_elem a [9] = '{default: '0};
    t_res  o [9];
    inverse_board board = new();
    int cycles = 0;
    int wait_left = 0;
    bit hold_recv = 0;

    always #5 i_clk = ~i_clk;

    matrix3_inverse u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_a00(a[0]), .i_a01(a[1]), .i_a02(a[2]),
        .i_a10(a[3]), .i_a11(a[4]), .i_a12(a[5]),
        .i_a20(a[6]), .i_a21(a[7]), .i_a22(a[8]),
        .o_valid, .i_stall,
        .o_inv00(o[0]), .o_inv01(o[1]), .o_inv02(o[2]),
        .o_inv10(o[3]), .o_inv11(o[4]), .o_inv12(o[5]),
        .o_inv20(o[6]), .o_inv21(o[7]), .o_inv22(o[8]),
        .o_singular, .o_saturated
    );

    // Keep valid up across back-to-back transactions; drop it only for a gap.
    task automatic send_matrix(t_elem m [9], int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < 9; k++) a[k] <= m[k];
        do @(posedge i_clk); while (o_stall);
        board.note_matrix(m);
    endtask

    function automatic t_elem rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return t_elem'($urandom_range(0, 8) - 4);
            3: return t_elem'($urandom_range(0, 8192) - 4096);
            default: return t_elem'($urandom);
        endcase
    endfunction

    // Receiver: check on each accepted transaction, then hold off a drawn count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                board.check_result(o, o_singular, o_saturated);
                wait_left = $urandom_range(0, 19);
            end else if (wait_left > 0) begin
                wait_left--;
            end
            i_stall <= hold_recv || (wait_left != 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_elem m [9];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity, zero, singular rows, extremes, saturating inverse
        m = '{16'sh1000, 0, 0, 0, 16'sh1000, 0, 0, 0, 16'sh1000};
        send_matrix(m, 0);
        m = '{default: '0};
        send_matrix(m, 0);
        m = '{default: 16'sh7fff};
        send_matrix(m, 0);
        m = '{default: 16'sh8000};
        send_matrix(m, 1);
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m, 0);
        m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m, 0);
        m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        send_matrix(m, 2);
        m = '{16'sh7fff, 16'sh8000, 0, 16'sh8000, 16'sh7fff, 0, 0, 0, 1};
        send_matrix(m, 0);
        m = '{16'sh1000, 16'sh2000, 16'sh3000, 16'sh2000, 16'sh4000, 16'sh6000, 1, 2, 3};
        send_matrix(m, 0);
        m = '{0, 16'sh1000, 0, 16'sh1000, 0, 0, 0, 0, 16'sh1000};
        send_matrix(m, 0);
        m = '{16'shffff, 16'sh5555, 16'shaaaa, 16'sh1234, 16'shffff, 16'sh0f0f,
              16'shf0f0, 16'sh8001, 16'shffff};
        send_matrix(m, 0);
        m = '{3, 0, 0, 0, 3, 0, 0, 0, 3};
        send_matrix(m, 0);

        for (int n = 0; n < 1300; n++) begin
            if (n == 300) begin
                // back up the pipeline behind a long receiver hold-off
                hold_recv = 1;
                fork
                    begin repeat (150) @(posedge i_clk); hold_recv = 0; end
                join_none
            end
            if (n == 700) begin
                i_valid <= 1'b0;
                wait (board.pending.size() == 0);
            end
            if ($urandom_range(0, 4) == 0) begin
                // rank-deficient: repeat a row
                for (int k = 0; k < 6; k++) m[k] = rand_elem();
                for (int k = 6; k < 9; k++) m[k] = m[k - 3 * $urandom_range(1, 2)];
            end else begin
                for (int k = 0; k < 9; k++) m[k] = rand_elem();
            end
            send_matrix(m, (n % 200 < 60) ? 0 : $urandom_range(0, 19));
        end
        i_valid <= 1'b0;

        wait (board.pending.size() == 0);
        repeat (60) @(posedge i_clk);
        if (board.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

[files.f]
rtl/mx3i_pkg.sv
rtl/mx3i_front.sv
rtl/mx3i_div_stage.sv
rtl/mx3i_back.sv
rtl/matrix3_inverse.sv
verif/matrix3_inverse_tb.sv
